// File: hw/rtl/setrk_pkg.sv
// Shared types, codes and widths of the speaker edge stream tracker.
package setrk_pkg;

  localparam int unsigned IN_TDATA_W   = 104;
  localparam int unsigned OUT_TDATA_W  = 232;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam logic [6:0]  MAX_EDGES    = 7'd64;

  localparam logic CFG_IDX_VERSION  = 1'b0;
  localparam logic CFG_IDX_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    CMD_CAPS    = 3'd0,
    CMD_CONTROL = 3'd1,
    CMD_SYNC    = 3'd2,
    CMD_HEADER  = 3'd3,
    CMD_DELTA   = 3'd4,
    CMD_UNKNOWN = 3'd5,
    CMD_EMPTY   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    CTL_START = 3'd0,
    CTL_STOP  = 3'd1,
    CTL_RESET = 3'd2,
    CTL_HINT  = 3'd3,
    CTL_NOP   = 3'd4
  } ctl_op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DUP         = 3'd1,
    ST_GAP         = 3'd2,
    ST_MALFORMED   = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_BAD_VERSION = 3'd5
  } status_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [3:0] {
    OP_DELTA,
    OP_EMPTY,
    OP_MALFORMED,
    OP_BAD_VERSION,
    OP_NOP,
    OP_START,
    OP_STOP,
    OP_RESET,
    OP_HINT,
    OP_SYNC,
    OP_HDR_BAD,
    OP_HDR
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] seq;
    logic [31:0] value;     // delta for edge items, base time otherwise
    logic        level;
    logic [6:0]  count;
    logic        over_cap;
  } op_t;

  typedef struct packed {
    logic [7:0] supported_version;
    logic [6:0] edge_capacity;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic        edge_valid;
    logic [31:0] edge_time;
    logic        edge_level;
    logic        accepting_now;
    logic [31:0] packet_total;
    logic [31:0] malformed_total;
    logic [31:0] duplicate_total;
    logic [31:0] gap_total;
    logic [31:0] resync_total;
    logic [31:0] edge_total;
  } res_t;

endpackage

// File: hw/rtl/setrk_front.sv
// Front end: unpacks an input item and classifies it into one operation.
module setrk_front (
  input  setrk_pkg::cfg_t                        cfg,
  input  logic [2:0]                             cmd,
  input  logic [setrk_pkg::IN_TDATA_W-1:0]       tdata,
  output setrk_pkg::op_t                         op
);

  logic        ok;
  logic [7:0]  fver;
  logic [2:0]  ctl;
  logic [15:0] seq;
  logic [31:0] base;
  logic        lvl;
  logic [6:0]  cnt;
  logic [31:0] dlt;

  assign ok   = tdata[0];
  assign fver = tdata[8:1];
  assign ctl  = tdata[11:9];
  assign seq  = tdata[27:12];
  assign base = tdata[59:28];
  assign lvl  = tdata[60];
  assign cnt  = tdata[67:61];
  assign dlt  = tdata[99:68];

  always_comb begin
    op          = '0;
    op.seq      = seq;
    op.level    = lvl;
    op.count    = cnt;
    op.over_cap = cnt > cfg.edge_capacity;
    op.value    = (setrk_pkg::cmd_t'(cmd) == setrk_pkg::CMD_DELTA) ? dlt : base;
    op.kind     = setrk_pkg::OP_MALFORMED;
    unique case (setrk_pkg::cmd_t'(cmd))
      setrk_pkg::CMD_CAPS: begin
        if (ok) begin
          op.kind = setrk_pkg::OP_NOP;
        end else if (fver != 8'd0 && fver != cfg.supported_version) begin
          op.kind = setrk_pkg::OP_BAD_VERSION;
        end else begin
          op.kind = setrk_pkg::OP_MALFORMED;
        end
      end
      setrk_pkg::CMD_CONTROL: begin
        if (!ok) begin
          op.kind = setrk_pkg::OP_MALFORMED;
        end else begin
          unique case (setrk_pkg::ctl_op_t'(ctl))
            setrk_pkg::CTL_START: op.kind = setrk_pkg::OP_START;
            setrk_pkg::CTL_STOP:  op.kind = setrk_pkg::OP_STOP;
            setrk_pkg::CTL_RESET: op.kind = setrk_pkg::OP_RESET;
            setrk_pkg::CTL_HINT:  op.kind = setrk_pkg::OP_HINT;
            default:              op.kind = setrk_pkg::OP_NOP;
          endcase
        end
      end
      setrk_pkg::CMD_SYNC: begin
        op.kind = ok ? setrk_pkg::OP_SYNC : setrk_pkg::OP_MALFORMED;
      end
      setrk_pkg::CMD_HEADER: begin
        // a bad header is still ignored when not accepting; the back decides
        op.kind = (!ok || cnt > setrk_pkg::MAX_EDGES) ? setrk_pkg::OP_HDR_BAD
                                                      : setrk_pkg::OP_HDR;
      end
      setrk_pkg::CMD_DELTA: op.kind = setrk_pkg::OP_DELTA;
      setrk_pkg::CMD_EMPTY: op.kind = setrk_pkg::OP_EMPTY;
      default:              op.kind = setrk_pkg::OP_MALFORMED;
    endcase
  end

endmodule

// File: hw/rtl/setrk_fifo.sv
// Short queue of classified operations between front and back.
module setrk_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  setrk_pkg::op_t  din,
  output logic            full,
  input  logic            pop,
  output setrk_pkg::op_t  dout,
  output logic            not_empty
);

  setrk_pkg::op_t                      mem_r [setrk_pkg::FIFO_DEPTH];
  logic [setrk_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [setrk_pkg::FIFO_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [setrk_pkg::FIFO_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full      = cnt_r == setrk_pkg::FIFO_CNT_W'(setrk_pkg::FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hw/rtl/setrk_back.sv
// Back end: sequence tracking, timeline, counters and the output register.
module setrk_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  setrk_pkg::op_t  op,
  output logic            pop,
  input  logic            out_ready,
  output logic            out_valid,
  output setrk_pkg::res_t res
);

  logic        have_r, have_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] tl_r, tl_nxt;
  logic        lvl_r, lvl_nxt;
  logic [6:0]  br_r, br_nxt;
  logic [31:0] packets_r, packets_nxt;
  logic [31:0] malformed_r, malformed_nxt;
  logic [31:0] dups_r, dups_nxt;
  logic [31:0] gaps_r, gaps_nxt;
  logic [31:0] resyncs_r, resyncs_nxt;
  logic [31:0] edges_r, edges_nxt;

  logic               out_valid_r;
  setrk_pkg::res_t    res_r, res_nxt;
  setrk_pkg::status_t status, seq_st;
  logic               ev, el;
  logic [31:0]        et;
  logic [15:0]        exp_inc;

  assign pop       = op_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign exp_inc   = exp_r + 16'd1;

  always_comb begin
    if (!have_r) begin
      seq_st = setrk_pkg::ST_OK;
    end else if (op.seq == exp_r) begin
      seq_st = setrk_pkg::ST_DUP;
    end else if (op.seq != exp_inc) begin
      seq_st = setrk_pkg::ST_GAP;
    end else begin
      seq_st = setrk_pkg::ST_OK;
    end
  end

  always_comb begin
    have_nxt      = have_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    tl_nxt        = tl_r;
    lvl_nxt       = lvl_r;
    br_nxt        = br_r;
    packets_nxt   = packets_r;
    malformed_nxt = malformed_r;
    dups_nxt      = dups_r;
    gaps_nxt      = gaps_r;
    resyncs_nxt   = resyncs_r;
    edges_nxt     = edges_r;
    status        = setrk_pkg::ST_OK;
    ev            = 1'b0;
    et            = 32'd0;
    el            = 1'b0;

    // any frame closes an open batch; empty frames are not packets
    if (op.kind != setrk_pkg::OP_DELTA) begin
      br_nxt = 7'd0;
      if (op.kind != setrk_pkg::OP_EMPTY) begin
        packets_nxt = packets_r + 32'd1;
      end
    end

    case (op.kind) inside
      setrk_pkg::OP_DELTA: begin
        if (br_r != 7'd0) begin
          tl_nxt    = tl_r + op.value;
          lvl_nxt   = ~lvl_r;
          edges_nxt = edges_r + 32'd1;
          br_nxt    = br_r - 7'd1;
          ev        = 1'b1;
          et        = tl_nxt;
          el        = lvl_nxt;
        end
      end
      setrk_pkg::OP_EMPTY, setrk_pkg::OP_MALFORMED: begin
        malformed_nxt = malformed_r + 32'd1;
        status        = setrk_pkg::ST_MALFORMED;
      end
      setrk_pkg::OP_BAD_VERSION: begin
        malformed_nxt = malformed_r + 32'd1;
        status        = setrk_pkg::ST_BAD_VERSION;
      end
      setrk_pkg::OP_START: acc_nxt = 1'b1;
      setrk_pkg::OP_STOP:  acc_nxt = 1'b0;
      setrk_pkg::OP_RESET: begin
        have_nxt = 1'b0;
        exp_nxt  = 16'd0;
        acc_nxt  = 1'b0;
        tl_nxt   = 32'd0;
        lvl_nxt  = 1'b0;
      end
      setrk_pkg::OP_HINT: resyncs_nxt = resyncs_r + 32'd1;
      setrk_pkg::OP_SYNC: begin
        status = seq_st;
        if (seq_st == setrk_pkg::ST_DUP) begin
          dups_nxt = dups_r + 32'd1;
        end else begin
          if (seq_st == setrk_pkg::ST_GAP) begin
            gaps_nxt = gaps_r + 32'd1;
          end
          tl_nxt      = op.value;
          lvl_nxt     = op.level;
          acc_nxt     = 1'b1;
          resyncs_nxt = resyncs_r + 32'd1;
          exp_nxt     = op.seq;
          have_nxt    = 1'b1;
        end
      end
      setrk_pkg::OP_HDR_BAD: begin
        if (acc_r) begin
          malformed_nxt = malformed_r + 32'd1;
          status        = setrk_pkg::ST_MALFORMED;
        end
      end
      setrk_pkg::OP_HDR: begin
        if (acc_r) begin
          status = seq_st;
          if (seq_st == setrk_pkg::ST_DUP) begin
            dups_nxt = dups_r + 32'd1;
          end else begin
            if (seq_st == setrk_pkg::ST_GAP) begin
              gaps_nxt    = gaps_r + 32'd1;
              resyncs_nxt = resyncs_r + 32'd1;
            end
            exp_nxt  = op.seq;
            have_nxt = 1'b1;
            tl_nxt   = op.value;
            if (op.over_cap) begin
              malformed_nxt = malformed_r + 32'd1;
              status        = setrk_pkg::ST_OVERFLOW;
            end else begin
              br_nxt = op.count;
            end
          end
        end
      end
      default: ;
    endcase

    res_nxt.status          = status;
    res_nxt.edge_valid      = ev;
    res_nxt.edge_time       = et;
    res_nxt.edge_level      = el;
    res_nxt.accepting_now   = acc_nxt;
    res_nxt.packet_total    = packets_nxt;
    res_nxt.malformed_total = malformed_nxt;
    res_nxt.duplicate_total = dups_nxt;
    res_nxt.gap_total       = gaps_nxt;
    res_nxt.resync_total    = resyncs_nxt;
    res_nxt.edge_total      = edges_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      exp_r       <= 16'd0;
      acc_r       <= 1'b0;
      tl_r        <= 32'd0;
      lvl_r       <= 1'b0;
      br_r        <= 7'd0;
      packets_r   <= 32'd0;
      malformed_r <= 32'd0;
      dups_r      <= 32'd0;
      gaps_r      <= 32'd0;
      resyncs_r   <= 32'd0;
      edges_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        have_r      <= have_nxt;
        exp_r       <= exp_nxt;
        acc_r       <= acc_nxt;
        tl_r        <= tl_nxt;
        lvl_r       <= lvl_nxt;
        br_r        <= br_nxt;
        packets_r   <= packets_nxt;
        malformed_r <= malformed_nxt;
        dups_r      <= dups_nxt;
        gaps_r      <= gaps_nxt;
        resyncs_r   <= resyncs_nxt;
        edges_r     <= edges_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: hw/rtl/speaker_edge_stream_tracker.sv
// Top level of the speaker edge stream tracker: config registers, front, queue, back.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   in_      | in  | in_tvalid/in_tready  | tuser: command; tdata: decoded frame fields
//   out_     | out | out_tvalid/out_tready| tuser: status; tdata: edge and counters
//   cfg_     | in  | cfg_we               | cfg_index selects register, cfg_wdata value
//
// One item per cycle sustained while out_tready is held high; an accepted item is
// written to the queue and then popped by the back end into the output register.
// Reset is synchronous: tracking state and counters clear, the config registers
// return to version 1 and capacity 64. A stalled output fills the four-entry queue
// before in_tready drops.
module speaker_edge_stream_tracker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] decode_ok, [8:1] frame_version, [11:9] control_op, [27:12] sequence_req,
  // [59:28] base_time, [60] level_in, [67:61] edge_count, [99:68] delta, rest zero
  input  logic [setrk_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] command
  input  logic [2:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] edge_valid, [32:1] edge_time, [33] edge_level, [34] accepting_now,
  // [66:35] packet_total, [98:67] malformed_total, [130:99] duplicate_total,
  // [162:131] gap_total, [194:163] resync_total, [226:195] edge_total, rest zero
  output logic [setrk_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [2:0]                            out_tuser,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [7:0]                            cfg_wdata
);

  setrk_pkg::cfg_t cfg_r;
  setrk_pkg::op_t  front_op;
  setrk_pkg::op_t  queue_op;
  setrk_pkg::res_t res;
  logic            fifo_full;
  logic            fifo_not_empty;
  logic            fifo_pop;
  logic            push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supported_version <= 8'd1;
      cfg_r.edge_capacity     <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == setrk_pkg::CFG_IDX_VERSION) begin
        cfg_r.supported_version <= cfg_wdata;
      end else begin
        cfg_r.edge_capacity <= cfg_wdata[6:0];
      end
    end
  end

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  setrk_front u_front (
    .cfg   (cfg_r),
    .cmd   (in_tuser),
    .tdata (in_tdata),
    .op    (front_op)
  );

  setrk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (front_op),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .dout      (queue_op),
    .not_empty (fifo_not_empty)
  );

  setrk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (fifo_not_empty),
    .op        (queue_op),
    .pop       (fifo_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .res       (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {5'd0,
                      res.edge_total,
                      res.resync_total,
                      res.gap_total,
                      res.duplicate_total,
                      res.malformed_total,
                      res.packet_total,
                      res.accepting_now,
                      res.edge_level,
                      res.edge_time,
                      res.edge_valid};

endmodule

// File: hw/rtl/setrk_checker.sv
// Port-level checks of the speaker edge stream tracker, bound to the top level.
module setrk_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [setrk_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                        out_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no edge means zero time and level
  a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[33:1] == 33'd0)
    else $error("edge fields set without an edge");

  // an emitted edge always comes with ok status
  a_edge_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tuser == setrk_pkg::ST_OK)
    else $error("edge carried with non-ok status");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind speaker_edge_stream_tracker setrk_checker u_setrk_checker (.*);

// File: dv/speaker_edge_stream_tracker_tb.sv
// Self-checking testbench for speaker_edge_stream_tracker: directed frames, random streams.
module speaker_edge_stream_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import setrk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        ok;
    logic [7:0]  fver;
    logic [2:0]  op;
    logic [15:0] seq;
    logic [31:0] base;
    logic        lvl;
    logic [6:0]  count;
    logic [31:0] delta;
  } frame_t;

  typedef logic [31:0] field_row_t [11];

  class edge_stream_scoreboard;
    bit [7:0]  cfg_version  = 8'd1;
    bit [6:0]  cfg_capacity = MAX_EDGES;
    bit        seq_valid;
    bit [15:0] seq_expect;
    bit        accepting;
    bit [31:0] timeline;
    bit        level;
    bit [6:0]  batch_left;
    bit [31:0] packet_cnt, malformed_cnt, dup_cnt, gap_cnt, resync_cnt, edge_cnt;
    res_t      pending_results[$];
    int        mismatches, unexpected, checked;
    int        status_seen[8];
    string     field_names[11] = '{"status", "edge_valid", "edge_time", "edge_level",
                                   "accepting_now", "packet_total", "malformed_total",
                                   "duplicate_total", "gap_total", "resync_total",
                                   "edge_total"};

    function void clear_stream();
      seq_valid  = 1'b0;
      seq_expect = '0;
      accepting  = 1'b0;
      timeline   = '0;
      level      = 1'b0;
      batch_left = '0;
    endfunction

    function status_t check_seq(bit [15:0] seq);
      if (!seq_valid) begin
        seq_expect = seq;
        seq_valid  = 1'b1;
        return ST_OK;
      end
      if (seq == seq_expect) begin
        dup_cnt++;
        return ST_DUP;
      end
      if (seq != seq_expect + 16'd1) begin
        gap_cnt++;
        seq_expect = seq;
        return ST_GAP;
      end
      seq_expect = seq;
      return ST_OK;
    endfunction

    // Predict the result of one accepted item and queue it.
    function void note_frame(frame_t f);
      res_t r;
      r = '0;
      r.status = ST_OK;
      if (f.cmd == CMD_DELTA) begin
        if (batch_left != 0) begin
          timeline += f.delta;
          level = ~level;
          edge_cnt++;
          batch_left--;
          r.edge_valid = 1'b1;
          r.edge_time  = timeline;
          r.edge_level = level;
        end
      end else begin
        // any frame closes an open batch
        batch_left = '0;
        if (f.cmd == CMD_EMPTY) begin
          malformed_cnt++;
          r.status = ST_MALFORMED;
        end else begin
          packet_cnt++;
          case (f.cmd)
            CMD_CAPS: begin
              if (!f.ok) begin
                malformed_cnt++;
                r.status = (f.fver != 0 && f.fver != cfg_version) ? ST_BAD_VERSION
                                                                   : ST_MALFORMED;
              end
            end
            CMD_CONTROL: begin
              if (!f.ok) begin
                malformed_cnt++;
                r.status = ST_MALFORMED;
              end else begin
                case (f.op)
                  CTL_START: accepting = 1'b1;
                  CTL_STOP:  accepting = 1'b0;
                  CTL_RESET: clear_stream();
                  CTL_HINT:  resync_cnt++;
                  default: ;
                endcase
              end
            end
            CMD_SYNC: begin
              if (!f.ok) begin
                malformed_cnt++;
                r.status = ST_MALFORMED;
              end else begin
                r.status = check_seq(f.seq);
                if (r.status != ST_DUP) begin
                  timeline   = f.base;
                  level      = f.lvl;
                  accepting  = 1'b1;
                  resync_cnt++;
                  seq_expect = f.seq;
                  seq_valid  = 1'b1;
                end
              end
            end
            CMD_HEADER: begin
              // a header while not accepting is only counted as a packet
              if (accepting) begin
                if (!f.ok || f.count > MAX_EDGES) begin
                  malformed_cnt++;
                  r.status = ST_MALFORMED;
                end else begin
                  r.status = check_seq(f.seq);
                  if (r.status != ST_DUP) begin
                    if (r.status == ST_GAP) resync_cnt++;
                    timeline = f.base;
                    if (f.count > cfg_capacity) begin
                      malformed_cnt++;
                      r.status = ST_OVERFLOW;
                    end else begin
                      batch_left = f.count;
                    end
                  end
                end
              end
            end
            default: begin
              malformed_cnt++;
              r.status = ST_MALFORMED;
            end
          endcase
        end
      end
      r.accepting_now   = accepting;
      r.packet_total    = packet_cnt;
      r.malformed_total = malformed_cnt;
      r.duplicate_total = dup_cnt;
      r.gap_total       = gap_cnt;
      r.resync_total    = resync_cnt;
      r.edge_total      = edge_cnt;
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    function field_row_t split(res_t r);
      return '{32'(r.status), 32'(r.edge_valid), r.edge_time, 32'(r.edge_level),
               32'(r.accepting_now), r.packet_total, r.malformed_total,
               r.duplicate_total, r.gap_total, r.resync_total, r.edge_total};
    endfunction

    function void check_result(res_t got);
      res_t       want;
      field_row_t w;
      field_row_t a;
      string      diffs;
      if (pending_results.size() == 0) begin
        if (mismatches + unexpected < 10)
          $display("unexpected result: status %0d", got.status);
        unexpected++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      w = split(want);
      a = split(got);
      diffs = "";
      foreach (w[i])
        if (w[i] !== a[i])
          diffs = {diffs, $sformatf(" %s exp %0h got %0h", field_names[i], w[i], a[i])};
      if (diffs != "") begin
        if (mismatches + unexpected < 10) $display("result %0d mismatch:%s", checked, diffs);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = 1'b0;
  logic [7:0]            cfg_wdata  = '0;

  edge_stream_scoreboard sb = new();
  bit steady;
  int items_sent;
  int settings_used;
  int cycle_count;

  speaker_edge_stream_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** speaker_edge_stream_tracker: FAILED **");
      $finish;
    end
  end

  // Result side: random backpressure, check each accepted item.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(res_t'({out_tuser, out_tdata[0], out_tdata[32:1], out_tdata[33],
                              out_tdata[34], out_tdata[66:35], out_tdata[98:67],
                              out_tdata[130:99], out_tdata[162:131], out_tdata[194:163],
                              out_tdata[226:195]}));
    out_tready <= steady || ($urandom_range(99) >= 37);
  end

  function automatic frame_t mk(logic [2:0] cmd, logic ok = 1'b1);
    frame_t f;
    f     = '0;
    f.cmd = cmd;
    f.ok  = ok;
    return f;
  endfunction

  function automatic frame_t caps_frame(logic [7:0] fver, logic ok = 1'b1);
    frame_t f;
    f      = mk(CMD_CAPS, ok);
    f.fver = fver;
    return f;
  endfunction

  function automatic frame_t ctl_frame(logic [2:0] op, logic ok = 1'b1);
    frame_t f;
    f    = mk(CMD_CONTROL, ok);
    f.op = op;
    return f;
  endfunction

  function automatic frame_t sync_frame(logic [15:0] seq, logic [31:0] base, logic lvl,
                                        logic ok = 1'b1);
    frame_t f;
    f      = mk(CMD_SYNC, ok);
    f.seq  = seq;
    f.base = base;
    f.lvl  = lvl;
    return f;
  endfunction

  function automatic frame_t hdr_frame(logic [15:0] seq, logic [31:0] base,
                                       logic [6:0] count, logic ok = 1'b1);
    frame_t f;
    f       = mk(CMD_HEADER, ok);
    f.seq   = seq;
    f.base  = base;
    f.count = count;
    return f;
  endfunction

  function automatic frame_t delta_frame(logic [31:0] d);
    frame_t f;
    f       = mk(CMD_DELTA);
    f.delta = d;
    return f;
  endfunction

  // Mostly the next sequence number, sometimes a repeat or a jump.
  function automatic logic [15:0] next_seq();
    int r;
    r = $urandom_range(99);
    if (!sb.seq_valid || r >= 92) return 16'($urandom);
    if (r >= 85) return sb.seq_expect;
    return sb.seq_expect + 16'd1;
  endfunction

  task automatic send_frame(frame_t f);
    if (!steady)
      while ($urandom_range(99) < 37) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tuser  <= f.cmd;
    in_tdata  <= IN_TDATA_W'({f.delta, f.count, f.lvl, f.base, f.seq, f.op, f.fver, f.ok});
    do @(posedge clk); while (!in_tready);
    sb.note_frame(f);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] ver, logic [6:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_VERSION;
    cfg_wdata <= ver;
    @(posedge clk);
    cfg_index <= CFG_IDX_CAPACITY;
    cfg_wdata <= {1'b0, cap};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cfg_version  = ver;
    sb.cfg_capacity = cap;
    settings_used++;
  endtask

  task automatic random_phase(int n, bit pause_midway);
    frame_t     f;
    int         done;
    int         pick;
    int         r;
    int         n_deltas;
    bit         paused;
    logic [6:0] count;
    done   = 0;
    paused = 1'b0;
    while (done < n) begin
      if (pause_midway && !paused && done >= n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (!sb.accepting) begin
          if ($urandom_range(1)) send_frame(ctl_frame(CTL_START));
          else send_frame(sync_frame(next_seq(), $urandom, 1'($urandom_range(1))));
          done++;
        end
        r = $urandom_range(99);
        if (r < 70)      count = 7'($urandom_range(6));
        else if (r < 85) count = 7'($urandom_range(64));
        else if (r < 95) count = sb.cfg_capacity + 7'($urandom_range(2));
        else             count = 7'($urandom_range(127, 65));
        f = hdr_frame(next_seq(), $urandom, count, $urandom_range(19) != 0);
        send_frame(f);
        n_deltas = (f.count > MAX_EDGES) ? 0 : int'(f.count);
        r = $urandom_range(99);
        if (r < 8 && n_deltas > 0) n_deltas = int'($urandom_range(n_deltas - 1));
        for (int k = 0; k < n_deltas; k++)
          send_frame(delta_frame(($urandom_range(3) == 0) ? $urandom
                                                          : $urandom_range(5000, 1)));
        // stray delta after the batch has run out
        if (r >= 95) send_frame(delta_frame($urandom));
        done += 1 + n_deltas;
      end else begin
        if (pick < 70)
          f = sync_frame(next_seq(), $urandom, 1'($urandom_range(1)),
                         $urandom_range(19) != 0);
        else if (pick < 80)
          f = ctl_frame(3'($urandom_range(7)), $urandom_range(9) != 0);
        else if (pick < 88)
          f = caps_frame(($urandom_range(3) == 0) ? sb.cfg_version : 8'($urandom),
                         1'($urandom_range(1)));
        else begin
          f       = '0;
          f.cmd   = 3'($urandom_range(7));
          f.ok    = 1'($urandom_range(1));
          f.fver  = 8'($urandom);
          f.op    = 3'($urandom_range(7));
          f.seq   = 16'($urandom);
          f.base  = $urandom;
          f.lvl   = 1'($urandom_range(1));
          f.count = 7'($urandom_range(127));
          f.delta = $urandom;
        end
        send_frame(f);
        done++;
      end
    end
  endtask

  initial begin
    logic [7:0] versions[5];
    logic [6:0] capacities[5];
    versions   = '{8'd1, 8'd0, 8'hFF, 8'($urandom), 8'h5A};
    capacities = '{MAX_EDGES, 7'd0, 7'd3, 7'($urandom_range(64)), MAX_EDGES};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset register values.
    send_frame(caps_frame(8'd1));
    send_frame(caps_frame(8'd0, 1'b0));
    send_frame(caps_frame(8'd1, 1'b0));           // matches supported version
    send_frame(caps_frame(8'hFF, 1'b0));          // version mismatch
    send_frame(mk(CMD_EMPTY));
    send_frame(mk(CMD_UNKNOWN));
    send_frame(mk(3'd7));
    send_frame(delta_frame(32'hFFFF_FFFF));       // no batch open
    send_frame(hdr_frame(16'd7, 32'd0, 7'd3));    // not accepting yet
    send_frame(ctl_frame(CTL_START, 1'b0));
    send_frame(ctl_frame(3'd7));
    send_frame(ctl_frame(CTL_HINT));
    send_frame(ctl_frame(CTL_START));
    send_frame(hdr_frame(16'hFFFF, 32'hFFFF_FFF0, 7'd2));
    send_frame(delta_frame(32'h10));              // timeline wraps
    send_frame(delta_frame(32'hFFFF_FFFF));
    send_frame(hdr_frame(16'h0000, 32'd0, 7'd3)); // sequence wraps
    send_frame(delta_frame(32'd1));
    send_frame(caps_frame(8'd1));                 // closes the batch early
    send_frame(delta_frame(32'd1));
    send_frame(hdr_frame(16'h0000, 32'd5, 7'd1)); // duplicate
    send_frame(hdr_frame(16'h0005, 32'd100, 7'd1));
    send_frame(hdr_frame(16'h0006, 32'd0, 7'd65));
    send_frame(hdr_frame(16'h0006, 32'd0, 7'd127));
    send_frame(hdr_frame(16'h0006, 32'd0, 7'd1, 1'b0));
    send_frame(hdr_frame(16'h0006, 32'd0, 7'd0));
    send_frame(sync_frame(16'h1234, 32'hFFFF_FFFF, 1'b1));
    send_frame(sync_frame(16'h1234, 32'd0, 1'b0));
    send_frame(ctl_frame(CTL_STOP));
    send_frame(ctl_frame(CTL_RESET));
    send_frame(sync_frame(16'h8000, 32'd0, 1'b0));
    wait_drained();
    write_config(8'd1, 7'd2);
    send_frame(hdr_frame(16'h8001, 32'd0, 7'd3)); // over capacity
    send_frame(hdr_frame(16'h8002, 32'd0, 7'd2));
    send_frame(delta_frame(32'd7));
    send_frame(delta_frame(32'd9));

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_config(versions[p], capacities[p]);
      steady = (p == 1);
      random_phase(PHASE_ITEMS, p == 3);
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d items under %0d register settings, %0d results checked, %0d edges",
             items_sent, settings_used + 1, sb.checked, sb.edge_cnt);
    $display("status mix: ok %0d dup %0d gap %0d malformed %0d overflow %0d bad version %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_DUP], sb.status_seen[ST_GAP],
             sb.status_seen[ST_MALFORMED], sb.status_seen[ST_OVERFLOW],
             sb.status_seen[ST_BAD_VERSION]);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_results.size() == 0)
      $display("** speaker_edge_stream_tracker: PASSED **");
    else
      $display("** speaker_edge_stream_tracker: FAILED **");
    $finish;
  end

endmodule
